// ===== src/ppu_pkg.sv =====
`default_nettype none
package ppu_pkg;

    localparam int POOL_SIZE = 32;
    localparam int SLOT_W    = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    localparam logic [2:0] KIND_SPAWN_FREE  = 3'd0;
    localparam logic [2:0] KIND_SPAWN_EVICT = 3'd1;
    localparam logic [2:0] KIND_UPDATED     = 3'd2;
    localparam logic [2:0] KIND_REMOVED     = 3'd3;
    localparam logic [2:0] KIND_EMPTY       = 3'd4;

    localparam logic [2:0] REG_GRAVITY_X   = 3'd0;
    localparam logic [2:0] REG_GRAVITY_Y   = 3'd1;
    localparam logic [2:0] REG_ACTIVE_TIME = 3'd2;
    localparam logic [2:0] REG_FADE_TIME   = 3'd3;
    localparam logic [2:0] REG_FADE_MODE   = 3'd4;

    localparam logic [31:0] GRAVITY_X_RESET   = 32'd0;
    localparam logic [31:0] GRAVITY_Y_RESET   = 32'hFF38_0000;
    localparam logic [23:0] ACTIVE_TIME_RESET = 24'd131072;
    localparam logic [23:0] FADE_TIME_RESET   = 24'd65536;
    localparam logic [1:0]  FADE_MODE_RESET   = 2'd2;

    localparam logic [7:0]  ALPHA_FULL = 8'd255;

endpackage
`default_nettype wire

// ===== src/ppu_in_if.sv =====
`default_nettype none
interface ppu_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [23:0]        delta_time;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] spin_rate;
    logic [23:0]        start_scale;

    modport source (output valid, mode, delta_time, start_x, start_y, speed_x, speed_y,
                    spin_rate, start_scale, input ready);
    modport sink (input valid, mode, delta_time, start_x, start_y, speed_x, speed_y,
                  spin_rate, start_scale, output ready);
endinterface
`default_nettype wire

// ===== src/ppu_out_if.sv =====
`default_nettype none
interface ppu_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [4:0]         slot;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_rotation;
    logic [23:0]        out_scale;
    logic [7:0]         out_alpha;
    logic               last;

    modport source (output valid, kind, slot, out_x, out_y, out_rotation, out_scale,
                    out_alpha, last, input ready);
    modport sink (input valid, kind, slot, out_x, out_y, out_rotation, out_scale,
                  out_alpha, last, output ready);
endinterface
`default_nettype wire

// ===== src/particle_pool_update_unit.sv =====
// Spawn: one slot scanned a cycle for a free slot; if none is free, eviction shifts the age list.
// Tick: each live particle takes five saturating multiply-adds plus up to two fade divisions,
// and a shift of the age list on removal; a full output stalls spawn, tick and empty tick alike.
// Throughput: one item at a time; a shared 32x25 multiplier and a 24-step divider set it.
// Reset: asynchronous, active low; clears pool occupancy, count and registers to defaults.
// Particle stores are not cleared and are valid only after a spawn writes them.
`default_nettype none
module particle_pool_update_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    ppu_in_if.sink           items,
    ppu_out_if.source        results
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SHIFT, ST_SPAWN_WR, ST_EMPTY, ST_TICK_SEL, ST_TICK_LIFE,
        ST_MUL_A, ST_MUL_B, ST_FADE_CHK, ST_FADE_MUL, ST_DIV_INIT, ST_DIV, ST_DIV_DONE,
        ST_EMIT
    } state_t;

    localparam int SW = ppu_pkg::SLOT_W;
    localparam int CW = ppu_pkg::CNT_W;
    localparam int PS = ppu_pkg::POOL_SIZE;

    state_t state_reg;

    logic signed [31:0] gravity_x_reg, gravity_y_reg;
    logic [23:0]        active_time_reg, fade_time_reg;
    logic [1:0]         fade_mode_reg;

    logic               mode_reg;
    logic [23:0]        dt_reg;
    logic signed [31:0] start_x_reg, start_y_reg, speed_x_reg, speed_y_reg, spin_in_reg;
    logic [23:0]        start_scale_reg;

    logic signed [31:0] pos_x_mem [PS];
    logic signed [31:0] pos_y_mem [PS];
    logic signed [31:0] vel_x_mem [PS];
    logic signed [31:0] vel_y_mem [PS];
    logic signed [31:0] rot_mem [PS];
    logic signed [31:0] spin_mem [PS];
    logic [24:0]        life_mem [PS];
    logic [23:0]        base_mem [PS];
    logic [23:0]        scale_mem [PS];
    logic [7:0]         alpha_mem [PS];
    logic [SW-1:0]      age_mem [PS];
    logic [PS-1:0]      in_use_reg;

    logic [CW-1:0]      cnt_reg;
    logic [SW-1:0]      s_reg, cur_i_reg, j_reg, scan_reg;
    logic [2:0]         kind_reg, op_reg;
    logic [4:0]         bit_reg;
    logic               phase_reg, shift_spawn_reg;
    logic signed [25:0] life_reg;
    logic signed [56:0] prod_reg;
    logic [23:0]        rem_reg, dvd_reg, quo_reg;

    logic               out_valid_reg;
    logic [2:0]         out_kind_reg;
    logic [SW-1:0]      out_slot_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_rot_reg;
    logic [23:0]        out_scale_reg;
    logic [7:0]         out_alpha_reg;
    logic               out_last_reg;

    logic               space;
    logic               emit_now;
    logic [SW-1:0]      rd_idx;
    logic [SW-1:0]      age_rd;
    logic               shift_more;
    logic               dead;
    logic [23:0]        num;
    logic [23:0]        den;
    logic signed [31:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [56:0] product;
    logic signed [31:0] acc;
    logic signed [41:0] sum;
    logic signed [31:0] sat_val;
    logic [24:0]        trial;
    logic               ge;
    logic [23:0]        rem_next;

    assign space      = !out_valid_reg || results.ready;
    assign emit_now   = space && (state_reg == ST_SPAWN_WR || state_reg == ST_EMPTY ||
                                  state_reg == ST_EMIT);
    assign shift_more = ({1'b0, j_reg} + CW'(1)) < cnt_reg;
    assign dead       = life_reg[25] || (life_reg == 26'sd0);
    assign num        = (life_reg > 26'sd0) ? life_reg[23:0] : 24'd0;
    assign den        = (fade_time_reg == 24'd0) ? 24'd1 : fade_time_reg;

    always_comb
    begin
        case (state_reg)
            ST_SHIFT:    rd_idx = j_reg + SW'(1);
            ST_TICK_SEL: rd_idx = cur_i_reg;
            default:     rd_idx = '0;
        endcase
    end
    assign age_rd = age_mem[rd_idx];

    always_comb
    begin
        mul_b = $signed({1'b0, dt_reg});
        case (op_reg)
            3'd0:    mul_a = gravity_x_reg;
            3'd1:    mul_a = gravity_y_reg;
            3'd2:    mul_a = vel_x_mem[s_reg];
            3'd3:    mul_a = vel_y_mem[s_reg];
            default: mul_a = spin_mem[s_reg];
        endcase
        if (state_reg == ST_FADE_MUL)
        begin
            mul_b = $signed({1'b0, num});
            mul_a = phase_reg ? $signed({24'd0, ppu_pkg::ALPHA_FULL})
                              : $signed({8'd0, base_mem[s_reg]});
        end
    end
    assign product = mul_a * mul_b;

    always_comb
    begin
        case (op_reg)
            3'd0:    acc = vel_x_mem[s_reg];
            3'd1:    acc = vel_y_mem[s_reg];
            3'd2:    acc = pos_x_mem[s_reg];
            3'd3:    acc = pos_y_mem[s_reg];
            default: acc = rot_mem[s_reg];
        endcase
        sum = {{10{acc[31]}}, acc} + {prod_reg[56], prod_reg[56:16]};
        if (sum > 42'sd2147483647)
            sat_val = 32'sh7FFF_FFFF;
        else if (sum < -42'sd2147483648)
            sat_val = 32'sh8000_0000;
        else
            sat_val = sum[31:0];
    end

    assign trial    = {rem_reg, dvd_reg[23]};
    assign ge       = trial >= {1'b0, den};
    assign rem_next = ge ? 24'(trial - {1'b0, den}) : trial[23:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            gravity_x_reg   <= ppu_pkg::GRAVITY_X_RESET;
            gravity_y_reg   <= ppu_pkg::GRAVITY_Y_RESET;
            active_time_reg <= ppu_pkg::ACTIVE_TIME_RESET;
            fade_time_reg   <= ppu_pkg::FADE_TIME_RESET;
            fade_mode_reg   <= ppu_pkg::FADE_MODE_RESET;
            in_use_reg      <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ppu_pkg::REG_GRAVITY_X:   gravity_x_reg   <= cfg_data;
                    ppu_pkg::REG_GRAVITY_Y:   gravity_y_reg   <= cfg_data;
                    ppu_pkg::REG_ACTIVE_TIME: active_time_reg <= cfg_data[23:0];
                    ppu_pkg::REG_FADE_TIME:   fade_time_reg   <= cfg_data[23:0];
                    ppu_pkg::REG_FADE_MODE:   fade_mode_reg   <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && results.ready && !emit_now)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (items.valid)
                    begin
                        if (items.mode)
                            state_reg <= ST_SCAN;
                        else if (cnt_reg == '0)
                            state_reg <= ST_EMPTY;
                        else
                            state_reg <= ST_TICK_SEL;
                        cur_i_reg <= SW'(cnt_reg - CW'(1));
                        scan_reg  <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (!in_use_reg[scan_reg])
                    begin
                        s_reg     <= scan_reg;
                        kind_reg  <= ppu_pkg::KIND_SPAWN_FREE;
                        state_reg <= ST_SPAWN_WR;
                    end
                    else if (scan_reg == SW'(PS - 1))
                    begin
                        s_reg                 <= age_mem[0];
                        in_use_reg[age_mem[0]] <= 1'b0;
                        kind_reg              <= ppu_pkg::KIND_SPAWN_EVICT;
                        j_reg                 <= '0;
                        shift_spawn_reg       <= 1'b1;
                        state_reg             <= ST_SHIFT;
                    end
                    else
                        scan_reg <= scan_reg + SW'(1);
                end
                ST_SHIFT:
                begin
                    if (shift_more)
                        j_reg <= j_reg + SW'(1);
                    else
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                        if (shift_spawn_reg)
                            state_reg <= ST_SPAWN_WR;
                        else if (cur_i_reg == '0)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            cur_i_reg <= cur_i_reg - SW'(1);
                            state_reg <= ST_TICK_SEL;
                        end
                    end
                end
                ST_SPAWN_WR:
                begin
                    if (space)
                    begin
                        in_use_reg[s_reg] <= 1'b1;
                        cnt_reg           <= cnt_reg + CW'(1);
                        out_valid_reg     <= 1'b1;
                        out_kind_reg      <= kind_reg;
                        out_slot_reg      <= s_reg;
                        out_x_reg         <= start_x_reg;
                        out_y_reg         <= start_y_reg;
                        out_rot_reg       <= '0;
                        out_scale_reg     <= start_scale_reg;
                        out_alpha_reg     <= ppu_pkg::ALPHA_FULL;
                        out_last_reg      <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                end
                ST_EMPTY:
                begin
                    if (space)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= ppu_pkg::KIND_EMPTY;
                        out_slot_reg  <= '0;
                        out_x_reg     <= '0;
                        out_y_reg     <= '0;
                        out_rot_reg   <= '0;
                        out_scale_reg <= '0;
                        out_alpha_reg <= '0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_TICK_SEL:
                begin
                    s_reg     <= age_rd;
                    state_reg <= ST_TICK_LIFE;
                end
                ST_TICK_LIFE:
                begin
                    op_reg <= 3'd0;
                    if (life_mem[s_reg] == 25'd0)
                    begin
                        life_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        life_reg  <= $signed({1'b0, life_mem[s_reg]}) - $signed({2'b0, dt_reg});
                        state_reg <= ST_MUL_A;
                    end
                end
                ST_MUL_A:
                begin
                    prod_reg  <= product;
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B:
                begin
                    op_reg    <= op_reg + 3'd1;
                    state_reg <= (op_reg == 3'd4) ? ST_FADE_CHK : ST_MUL_A;
                end
                ST_FADE_CHK:
                begin
                    phase_reg <= !fade_mode_reg[0];
                    if (life_reg > $signed({2'b0, fade_time_reg}) || fade_mode_reg == 2'd0)
                        state_reg <= ST_EMIT;
                    else
                        state_reg <= ST_FADE_MUL;
                end
                ST_FADE_MUL:
                begin
                    prod_reg  <= product;
                    state_reg <= ST_DIV_INIT;
                end
                ST_DIV_INIT:
                begin
                    rem_reg   <= prod_reg[47:24];
                    dvd_reg   <= prod_reg[23:0];
                    bit_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg <= rem_next;
                    dvd_reg <= {dvd_reg[22:0], 1'b0};
                    quo_reg <= {quo_reg[22:0], ge};
                    bit_reg <= bit_reg + 5'd1;
                    if (bit_reg == 5'd23)
                        state_reg <= ST_DIV_DONE;
                end
                ST_DIV_DONE:
                begin
                    if (!phase_reg && fade_mode_reg[1])
                    begin
                        phase_reg <= 1'b1;
                        state_reg <= ST_FADE_MUL;
                    end
                    else
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (space)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= dead ? ppu_pkg::KIND_REMOVED : ppu_pkg::KIND_UPDATED;
                        out_slot_reg  <= s_reg;
                        out_x_reg     <= pos_x_mem[s_reg];
                        out_y_reg     <= pos_y_mem[s_reg];
                        out_rot_reg   <= rot_mem[s_reg];
                        out_scale_reg <= scale_mem[s_reg];
                        out_alpha_reg <= alpha_mem[s_reg];
                        out_last_reg  <= (cur_i_reg == '0);
                        if (dead)
                        begin
                            in_use_reg[s_reg] <= 1'b0;
                            j_reg             <= cur_i_reg;
                            shift_spawn_reg   <= 1'b0;
                            state_reg         <= ST_SHIFT;
                        end
                        else if (cur_i_reg == '0)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            cur_i_reg <= cur_i_reg - SW'(1);
                            state_reg <= ST_TICK_SEL;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && items.valid)
        begin
            mode_reg        <= items.mode;
            dt_reg          <= items.delta_time;
            start_x_reg     <= items.start_x;
            start_y_reg     <= items.start_y;
            speed_x_reg     <= items.speed_x;
            speed_y_reg     <= items.speed_y;
            spin_in_reg     <= items.spin_rate;
            start_scale_reg <= items.start_scale;
        end
        case (state_reg)
            ST_SHIFT:
            begin
                if (shift_more)
                    age_mem[j_reg] <= age_rd;
            end
            ST_SPAWN_WR:
            begin
                if (space)
                begin
                    pos_x_mem[s_reg] <= start_x_reg;
                    pos_y_mem[s_reg] <= start_y_reg;
                    vel_x_mem[s_reg] <= speed_x_reg;
                    vel_y_mem[s_reg] <= speed_y_reg;
                    spin_mem[s_reg]  <= spin_in_reg;
                    rot_mem[s_reg]   <= '0;
                    base_mem[s_reg]  <= start_scale_reg;
                    scale_mem[s_reg] <= start_scale_reg;
                    alpha_mem[s_reg] <= ppu_pkg::ALPHA_FULL;
                    life_mem[s_reg]  <= {1'b0, active_time_reg} + {1'b0, fade_time_reg};
                    age_mem[cnt_reg[SW-1:0]] <= s_reg;
                end
            end
            ST_MUL_B:
            begin
                case (op_reg)
                    3'd0:    vel_x_mem[s_reg] <= sat_val;
                    3'd1:    vel_y_mem[s_reg] <= sat_val;
                    3'd2:    pos_x_mem[s_reg] <= sat_val;
                    3'd3:    pos_y_mem[s_reg] <= sat_val;
                    default: rot_mem[s_reg]   <= sat_val;
                endcase
            end
            ST_FADE_CHK:
            begin
                if (life_reg > $signed({2'b0, fade_time_reg}))
                begin
                    scale_mem[s_reg] <= base_mem[s_reg];
                    alpha_mem[s_reg] <= ppu_pkg::ALPHA_FULL;
                end
            end
            ST_DIV_DONE:
            begin
                if (phase_reg)
                    alpha_mem[s_reg] <= quo_reg[7:0];
                else
                    scale_mem[s_reg] <= quo_reg;
            end
            ST_EMIT:
            begin
                if (space)
                    life_mem[s_reg] <= dead ? 25'd0 : life_reg[24:0];
            end
            default: ;
        endcase
    end

    assign items.ready          = (state_reg == ST_IDLE);
    assign results.valid        = out_valid_reg;
    assign results.kind         = out_kind_reg;
    assign results.slot         = 5'(out_slot_reg);
    assign results.out_x        = out_x_reg;
    assign results.out_y        = out_y_reg;
    assign results.out_rotation = out_rot_reg;
    assign results.out_scale    = out_scale_reg;
    assign results.out_alpha    = out_alpha_reg;
    assign results.last         = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(PS))
        else $error("active count above pool size");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |=> !items.ready)
        else $error("ready after accepting an item");
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.kind == ppu_pkg::KIND_EMPTY) |-> results.last)
        else $error("empty tick result not last");
    a_spawn_after_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPAWN_WR) |-> mode_reg)
        else $error("spawn write on a tick item");
`endif

endmodule
`default_nettype wire

// ===== test/particle_pool_update_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module particle_pool_update_unit_tb;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 200;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        logic        mode;
        logic [23:0] dt;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] spin;
        logic [23:0] scale;
    } particle_word_t;

    typedef struct {
        logic [2:0]  kind;
        logic [4:0]  slot;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] rot;
        logic [23:0] scale;
        logic [7:0]  alpha;
        logic        last;
    } particle_report_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    ppu_in_if  items_if ();
    ppu_out_if results_if ();

    particle_pool_update_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items_if),
        .results   (results_if)
    );

    // particle state mirror
    int          pos_x [ppu_pkg::POOL_SIZE];
    int          pos_y [ppu_pkg::POOL_SIZE];
    int          vel_x [ppu_pkg::POOL_SIZE];
    int          vel_y [ppu_pkg::POOL_SIZE];
    int          angle [ppu_pkg::POOL_SIZE];
    int          spin [ppu_pkg::POOL_SIZE];
    longint      life [ppu_pkg::POOL_SIZE];
    longint      base_scale [ppu_pkg::POOL_SIZE];
    longint      shown_scale [ppu_pkg::POOL_SIZE];
    longint      shown_alpha [ppu_pkg::POOL_SIZE];
    bit          occupied [ppu_pkg::POOL_SIZE];
    int          age_list [ppu_pkg::POOL_SIZE];
    int          live_count;

    int          grav_x;
    int          grav_y;
    longint      full_time;
    longint      fade_len;
    logic [1:0]  fade_sel;

    particle_report_t pending_reports[$];
    int          mismatches;
    int          stalled_cycles;
    int          burst_left;
    int          ready_pct;
    int          pattern_left;
    int          hold_left;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic longint scaled_by_dt(longint a, longint dt);
        return (a * dt) >>> 16;
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return int'(v);
    endfunction

    task automatic drop_entry(input int idx);
        int j;
        for (j = idx; j + 1 < live_count; j++)
            age_list[j] = age_list[j + 1];
        if (live_count > 0)
            live_count--;
    endtask

    task automatic push_report(input logic [2:0] kind, input int s, input int x, input int y,
                               input int rot, input longint scale, input longint alpha,
                               input bit last);
        particle_report_t r;
        r.kind  = kind;
        r.slot  = s[4:0];
        r.x     = x;
        r.y     = y;
        r.rot   = rot;
        r.scale = scale[23:0];
        r.alpha = alpha[7:0];
        r.last  = last;
        pending_reports.insert(pending_reports.size(), r);
    endtask

    task automatic advance_pool(input particle_word_t w);
        int s;
        int i;
        bit found;
        bit dead;
        logic [2:0] kind;
        longint lf;
        longint dt;
        longint num;
        longint den;
        if (w.mode)
        begin
            found = 0;
            kind = ppu_pkg::KIND_SPAWN_FREE;
            s = 0;
            for (i = 0; i < ppu_pkg::POOL_SIZE; i++)
            begin
                if (!found && !occupied[i])
                begin
                    found = 1;
                    s = i;
                end
            end
            if (!found)
            begin
                s = age_list[0];
                occupied[s] = 0;
                drop_entry(0);
                kind = ppu_pkg::KIND_SPAWN_EVICT;
            end
            pos_x[s] = w.sx;
            pos_y[s] = w.sy;
            vel_x[s] = w.vx;
            vel_y[s] = w.vy;
            spin[s] = w.spin;
            angle[s] = 0;
            base_scale[s] = w.scale;
            shown_scale[s] = w.scale;
            shown_alpha[s] = ppu_pkg::ALPHA_FULL;
            life[s] = full_time + fade_len;
            occupied[s] = 1;
            if (live_count < ppu_pkg::POOL_SIZE)
            begin
                age_list[live_count] = s;
                live_count++;
            end
            push_report(kind, s, pos_x[s], pos_y[s], 0, shown_scale[s], ppu_pkg::ALPHA_FULL,
                        1'b1);
        end
        else if (live_count == 0)
        begin
            push_report(ppu_pkg::KIND_EMPTY, 0, 0, 0, 0, 0, 0, 1'b1);
        end
        else
        begin
            dt = w.dt;
            for (i = live_count - 1; i >= 0; i--)
            begin
                s = age_list[i];
                lf = life[s];
                if (lf > 0)
                begin
                    lf -= dt;
                    vel_x[s] = clamp32(longint'(vel_x[s]) + scaled_by_dt(grav_x, dt));
                    vel_y[s] = clamp32(longint'(vel_y[s]) + scaled_by_dt(grav_y, dt));
                    pos_x[s] = clamp32(longint'(pos_x[s]) + scaled_by_dt(vel_x[s], dt));
                    pos_y[s] = clamp32(longint'(pos_y[s]) + scaled_by_dt(vel_y[s], dt));
                    angle[s] = clamp32(longint'(angle[s]) + scaled_by_dt(spin[s], dt));
                    if (lf > fade_len)
                    begin
                        shown_scale[s] = base_scale[s];
                        shown_alpha[s] = ppu_pkg::ALPHA_FULL;
                    end
                    else
                    begin
                        num = (lf > 0) ? lf : 0;
                        den = (fade_len != 0) ? fade_len : 1;
                        if (fade_sel[0])
                            shown_scale[s] = (base_scale[s] * num) / den;
                        if (fade_sel[1])
                            shown_alpha[s] = (255 * num) / den;
                    end
                end
                dead = (lf <= 0);
                life[s] = dead ? 0 : lf;
                push_report(dead ? ppu_pkg::KIND_REMOVED : ppu_pkg::KIND_UPDATED, s, pos_x[s],
                            pos_y[s], angle[s], shown_scale[s], shown_alpha[s], i == 0);
                if (dead)
                begin
                    occupied[s] = 0;
                    drop_entry(i);
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ready pattern, long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
        end
        if (pattern_left == 0)
        begin
            pattern_left = $urandom_range(20, 300);
            case ($urandom_range(0, 2))
                0: ready_pct = 100;
                1: ready_pct = 70;
                default: ready_pct = 25;
            endcase
        end
        pattern_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            results_if.ready <= 1'b0;
        end
        else
            results_if.ready <= ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge clk)
    begin
        particle_report_t e;
        if (results_if.valid && results_if.ready)
        begin
            if (pending_reports.size() == 0)
                report_mismatch($sformatf("unexpected word kind %0d slot %0d",
                                          results_if.kind, results_if.slot));
            else
            begin
                e = pending_reports.pop_front();
                if (results_if.kind !== e.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", results_if.kind, e.kind));
                if (results_if.slot !== e.slot)
                    report_mismatch($sformatf("slot %0d, want %0d", results_if.slot, e.slot));
                if (results_if.out_x !== e.x)
                    report_mismatch($sformatf("x %h, want %h", results_if.out_x, e.x));
                if (results_if.out_y !== e.y)
                    report_mismatch($sformatf("y %h, want %h", results_if.out_y, e.y));
                if (results_if.out_rotation !== e.rot)
                    report_mismatch($sformatf("rotation %h, want %h",
                                              results_if.out_rotation, e.rot));
                if (results_if.out_scale !== e.scale)
                    report_mismatch($sformatf("scale %h, want %h",
                                              results_if.out_scale, e.scale));
                if (results_if.out_alpha !== e.alpha)
                    report_mismatch($sformatf("alpha %0d, want %0d",
                                              results_if.out_alpha, e.alpha));
                if (results_if.last !== e.last)
                    report_mismatch($sformatf("last %b, want %b", results_if.last, e.last));
            end
        end
        if ((results_if.valid && results_if.ready) || (items_if.valid && items_if.ready))
            stalled_cycles = 0;
        else if (pending_reports.size() > 0 || items_if.valid)
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("particle_pool_update_unit verification failed");
            $finish;
        end
    end

    task automatic send_word(input particle_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                items_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        items_if.valid       <= 1'b1;
        items_if.mode        <= w.mode;
        items_if.delta_time  <= w.dt;
        items_if.start_x     <= w.sx;
        items_if.start_y     <= w.sy;
        items_if.speed_x     <= w.vx;
        items_if.speed_y     <= w.vy;
        items_if.spin_rate   <= w.spin;
        items_if.start_scale <= w.scale;
        do
            @(posedge clk);
        while (!items_if.ready);
        advance_pool(w);
    endtask

    task automatic drain;
        items_if.valid <= 1'b0;
        while (pending_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            ppu_pkg::REG_GRAVITY_X:   grav_x = value;
            ppu_pkg::REG_GRAVITY_Y:   grav_y = value;
            ppu_pkg::REG_ACTIVE_TIME: full_time = value[23:0];
            ppu_pkg::REG_FADE_TIME:   fade_len = value[23:0];
            ppu_pkg::REG_FADE_MODE:   fade_sel = value[1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] gx, input logic [31:0] gy, input logic [23:0] at,
                           input logic [23:0] ft, input logic [1:0] fm);
        drain();
        write_reg(ppu_pkg::REG_GRAVITY_X, gx);
        write_reg(ppu_pkg::REG_GRAVITY_Y, gy);
        write_reg(ppu_pkg::REG_ACTIVE_TIME, {8'd0, at});
        write_reg(ppu_pkg::REG_FADE_TIME, {8'd0, ft});
        write_reg(ppu_pkg::REG_FADE_MODE, {30'd0, fm});
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    function automatic particle_word_t spawn_word();
        particle_word_t w;
        w.mode  = 1'b1;
        w.dt    = 24'($urandom);
        w.sx    = pick32();
        w.sy    = pick32();
        w.vx    = pick32();
        w.vy    = pick32();
        w.spin  = pick32();
        w.scale = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom);
        return w;
    endfunction

    function automatic particle_word_t tick_word(input logic [23:0] dt);
        particle_word_t w;
        w = spawn_word();
        w.mode = 1'b0;
        w.dt   = dt;
        return w;
    endfunction

    function automatic logic [23:0] random_dt();
        case ($urandom_range(0, 9))
            0: return 24'($urandom);
            1: return 24'hFFFFFF;
            2: return 24'd0;
            default: return 24'($urandom_range(1, 24'h006000));
        endcase
    endfunction

    task automatic test_directed;
        particle_word_t w;
        send_word(tick_word(24'd5));
        w = spawn_word();
        w.sx = 32'h7FFF_FFFF; w.sy = 32'h8000_0000; w.vx = 32'h7FFF_FFFF;
        w.vy = 32'h8000_0000; w.spin = 32'h8000_0000; w.scale = 24'hFFFFFF;
        send_word(w);
        w.sx = 32'h8000_0000; w.sy = 32'h7FFF_FFFF; w.vx = 32'h8000_0000;
        w.vy = 32'h7FFF_FFFF; w.spin = 32'h7FFF_FFFF; w.scale = 24'd0;
        send_word(w);
        w.sx = 0; w.sy = 0; w.vx = 32'hFFFF_FFFF; w.vy = 1; w.spin = 32'hFFFF_FFFF;
        w.scale = 24'h010000;
        send_word(w);
        send_word(tick_word(24'd0));
        send_word(tick_word(24'd1));
        send_word(tick_word(24'h010000));
        send_word(tick_word(24'h00C000));
        send_word(tick_word(24'h00C000));
        send_word(tick_word(24'hFFFFFF));
        send_word(tick_word(24'h000100));
    endtask

    task automatic test_fade_modes;
        int m;
        int k;
        for (m = 0; m < 4; m++)
        begin
            set_all(m[0] ? 32'h7FFF_FFFF : 32'h8000_0000, m[1] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                    24'h008000, 24'h010000, m[1:0]);
            send_word(spawn_word());
            send_word(spawn_word());
            for (k = 0; k < 5; k++)
                send_word(tick_word(24'h004000));
        end
    endtask

    task automatic test_zero_times;
        set_all(32'd0, ppu_pkg::GRAVITY_Y_RESET, 24'd0, 24'd0, 2'd3);
        send_word(spawn_word());
        send_word(spawn_word());
        send_word(tick_word(24'h001000));
        set_all(32'd0, ppu_pkg::GRAVITY_Y_RESET, 24'h001000, 24'd0, 2'd3);
        send_word(spawn_word());
        send_word(tick_word(24'h000800));
        send_word(tick_word(24'h001000));
    endtask

    task automatic test_pool_full;
        int k;
        set_all(32'h0001_0000, 32'hFFFF_0000, 24'hFFFFFF, 24'hFFFFFF, 2'd3);
        for (k = 0; k < ppu_pkg::POOL_SIZE + 4; k++)
            send_word(spawn_word());
        send_word(tick_word(24'h000400));
        send_word(tick_word(24'hFFFFFF));
    endtask

    task automatic test_hold_off;
        int k;
        hold_request = 1;
        for (k = 0; k < 8; k++)
            send_word(spawn_word());
        send_word(tick_word(24'h000200));
    endtask

    task automatic test_random;
        int phase;
        int k;
        for (phase = 0; phase < 5; phase++)
        begin
            set_all(pick32(), pick32(), 24'($urandom_range(0, 24'h030000)),
                    24'($urandom_range(1, 24'h020000)), 2'($urandom_range(0, 3)));
            for (k = 0; k < 14; k++)
            begin
                if ($urandom_range(0, 99) < 45)
                    send_word(spawn_word());
                else
                    send_word(tick_word(random_dt()));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_if.valid = 1'b0;
        items_if.mode = 1'b0;
        items_if.delta_time = '0;
        items_if.start_x = '0;
        items_if.start_y = '0;
        items_if.speed_x = '0;
        items_if.speed_y = '0;
        items_if.spin_rate = '0;
        items_if.start_scale = '0;
        results_if.ready = 1'b0;
        mismatches = 0;
        stalled_cycles = 0;
        burst_left = 0;
        pattern_left = 0;
        ready_pct = 100;
        hold_left = 0;
        hold_request = 0;
        live_count = 0;
        grav_x = ppu_pkg::GRAVITY_X_RESET;
        grav_y = ppu_pkg::GRAVITY_Y_RESET;
        full_time = ppu_pkg::ACTIVE_TIME_RESET;
        fade_len = ppu_pkg::FADE_TIME_RESET;
        fade_sel = ppu_pkg::FADE_MODE_RESET;
        foreach (occupied[i])
        begin
            occupied[i] = 0;
            age_list[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fade_modes();
        test_zero_times();
        test_pool_full();
        test_hold_off();
        test_random();
        drain();
        if (mismatches == 0)
            $display("particle_pool_update_unit verification clean");
        else
            $display("particle_pool_update_unit verification failed");
        $finish;
    end

endmodule
`default_nettype wire
